>>> hdl/plrra_pkg.sv
// Package: shared widths and types for the priority-level round-robin arbiter.
package plrra_pkg;

   localparam int FIELD_PORTS  = 4;
   localparam int FIELD_LEVELS = 4;
   localparam int PORT_W       = 2;
   localparam int LEVEL_W      = 2;

   typedef logic [FIELD_PORTS-1:0] mask_type;
   typedef logic [LEVEL_W-1:0]     level_type;
   typedef logic [PORT_W-1:0]      port_type;

endpackage

>>> hdl/priority_level_round_robin_arbiter_core.sv
// Top level: strict-priority arbiter with a round-robin pointer for each QoS level.
//
//  channel | ports                                         | dir | transfer
//  req     | request_mask, level_port0..level_port3        | in  | req_valid & req_ready
//  rsp     | grant_valid, grant_port, grant_level          | out | rsp_valid & rsp_ready
//
// Every req transfer yields exactly one rsp transfer. One input register, one result register;
// a new transfer can be taken every cycle unless rsp stalls.
// The level/port search sits between those registers; the level pointers update as an
// item moves into the result register. Synchronous reset sets every pointer to PORTS-1.
// A stall on rsp holds the result register, then the input register, then req_ready.
module priority_level_round_robin_arbiter_core #(
   parameter int PORTS  = 4,
   parameter int LEVELS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  plrra_pkg::mask_type  req_request_mask,
   input  plrra_pkg::level_type req_level_port0,
   input  plrra_pkg::level_type req_level_port1,
   input  plrra_pkg::level_type req_level_port2,
   input  plrra_pkg::level_type req_level_port3,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_grant_valid,
   output plrra_pkg::port_type  rsp_grant_port,
   output plrra_pkg::level_type rsp_grant_level
);

   import plrra_pkg::*;

   localparam int PTR_W = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   logic                in_valid_ff;
   mask_type            in_mask_ff;
   level_type           in_level_ff [FIELD_PORTS];
   logic                out_valid_ff;
   logic                out_grant_ff;
   port_type            out_port_ff;
   level_type           out_level_ff;
   logic [PTR_W-1:0]    ptr_ff [LEVELS];

   logic                advance;
   logic [PORTS-1:0]    req_at_level [LEVELS];
   logic [LEVELS-1:0]   hit;
   logic [PTR_W-1:0]    pick [LEVELS];
   logic                found;
   logic [PTR_W-1:0]    win_port;
   logic [LVL_W-1:0]    win_lvl;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_mask_ff     <= req_request_mask;
         in_level_ff[0] <= req_level_port0;
         in_level_ff[1] <= req_level_port1;
         in_level_ff[2] <= req_level_port2;
         in_level_ff[3] <= req_level_port3;
      end
   end

   // per-level requester vectors; ports past the field set never request
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         for (int p = 0; p < PORTS; p++) begin
            if (p < FIELD_PORTS && l < FIELD_LEVELS) begin
               req_at_level[l][p] = in_mask_ff[p] && (in_level_ff[p] == LEVEL_W'(l));
            end else begin
               req_at_level[l][p] = 1'b0;
            end
         end
      end
   end

   // round-robin pick within each level, starting one past its pointer
   always_comb begin : rr_pick
      logic [PTR_W:0] cand;
      for (int l = 0; l < LEVELS; l++) begin
         hit[l]  = 1'b0;
         pick[l] = '0;
         for (int k = 0; k < PORTS; k++) begin
            cand = {1'b0, ptr_ff[l]} + (PTR_W+1)'(k + 1);
            if (cand >= (PTR_W+1)'(PORTS)) begin
               cand = cand - (PTR_W+1)'(PORTS);
            end
            if (!hit[l] && req_at_level[l][cand[PTR_W-1:0]]) begin
               hit[l]  = 1'b1;
               pick[l] = cand[PTR_W-1:0];
            end
         end
      end
   end

   // highest level with a hit wins
   always_comb begin
      found    = 1'b0;
      win_port = '0;
      win_lvl  = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (!found && hit[l]) begin
            found    = 1'b1;
            win_port = pick[l];
            win_lvl  = LVL_W'(l);
         end
      end
   end

   // result register and level pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int l = 0; l < LEVELS; l++) begin
            ptr_ff[l] <= PTR_W'(PORTS - 1);
         end
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance && found) begin
            ptr_ff[win_lvl] <= win_port;
         end
      end
      if (advance) begin
         out_grant_ff <= found;
         out_port_ff  <= found ? PORT_W'(win_port) : '0;
         out_level_ff <= found ? LEVEL_W'(win_lvl) : '0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_grant_valid = out_grant_ff;
   assign rsp_grant_port  = out_port_ff;
   assign rsp_grant_level = out_level_ff;

`ifndef SYNTH
   a_nogrant_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_grant_ff) |-> (out_port_ff == '0 && out_level_ff == '0))
      else $error("no-grant result carries nonzero port or level");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("item left input register but result register is empty");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_mask_ff)))
      else $error("stalled input register lost or changed its item");

   a_grant_requested: assert property (@(posedge clock) disable iff (reset)
      (advance && found) |-> req_at_level[win_lvl][win_port])
      else $error("grant to a port not requesting at the winning level");
`endif

endmodule

>>> tb/tb_top.sv
// Testbench for the priority-level round-robin arbiter: directed table, then random ticks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import plrra_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DIR_ROWS    = 22;
   localparam int HOLD_CYCLES = 60;
   localparam int EXP_DEPTH   = 64;

   typedef struct packed {
      logic      gv;
      port_type  port;
      level_type level;
   } grant_type;

   typedef struct packed {
      mask_type  mask;
      level_type l0;
      level_type l1;
      level_type l2;
      level_type l3;
      logic      typed;
      grant_type want;
   } dir_row_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   mask_type  req_request_mask;
   level_type req_level_port0;
   level_type req_level_port1;
   level_type req_level_port2;
   level_type req_level_port3;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_grant_valid;
   port_type  rsp_grant_port;
   level_type rsp_grant_level;

   grant_type exp_fifo [EXP_DEPTH];
   int        exp_wr = 0;
   int        exp_rd = 0;
   port_type  last_grant_port [FIELD_LEVELS];
   int        mismatch_count = 0;
   int        cycle_count = 0;
   bit        no_idle;
   bit        hold_rsp;

   // want is typed in only where the grant is plain from the inputs alone
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{4'h0, 2'd3, 2'd3, 2'd3, 2'd3, 1'b1, '{1'b0, 2'd0, 2'd0}},
      '{4'h1, 2'd0, 2'd0, 2'd0, 2'd0, 1'b1, '{1'b1, 2'd0, 2'd0}},
      '{4'hF, 2'd3, 2'd3, 2'd3, 2'd3, 1'b1, '{1'b1, 2'd0, 2'd3}},
      '{4'hF, 2'd3, 2'd3, 2'd3, 2'd3, 1'b0, '0},
      '{4'hF, 2'd3, 2'd3, 2'd3, 2'd3, 1'b0, '0},
      '{4'hF, 2'd3, 2'd3, 2'd3, 2'd3, 1'b0, '0},
      '{4'hF, 2'd3, 2'd3, 2'd3, 2'd3, 1'b0, '0},
      '{4'hF, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, '0},
      '{4'h8, 2'd0, 2'd0, 2'd0, 2'd3, 1'b1, '{1'b1, 2'd3, 2'd3}},
      '{4'h0, 2'd3, 2'd3, 2'd3, 2'd3, 1'b1, '{1'b0, 2'd0, 2'd0}},
      '{4'hF, 2'd3, 2'd0, 2'd0, 2'd0, 1'b1, '{1'b1, 2'd0, 2'd3}},
      '{4'hE, 2'd3, 2'd1, 2'd2, 2'd1, 1'b1, '{1'b1, 2'd2, 2'd2}},
      '{4'h5, 2'd1, 2'd0, 2'd1, 2'd0, 1'b0, '0},
      '{4'h5, 2'd1, 2'd0, 2'd1, 2'd0, 1'b0, '0},
      '{4'h5, 2'd1, 2'd0, 2'd1, 2'd0, 1'b0, '0},
      '{4'hF, 2'd2, 2'd1, 2'd2, 2'd1, 1'b0, '0},
      '{4'hF, 2'd1, 2'd1, 2'd1, 2'd1, 1'b0, '0},
      '{4'hA, 2'd3, 2'd0, 2'd3, 2'd0, 1'b0, '0},
      '{4'h2, 2'd0, 2'd2, 2'd0, 2'd0, 1'b1, '{1'b1, 2'd1, 2'd2}},
      '{4'h4, 2'd0, 2'd0, 2'd1, 2'd0, 1'b1, '{1'b1, 2'd2, 2'd1}},
      '{4'hF, 2'd0, 2'd3, 2'd3, 2'd0, 1'b0, '0},
      '{4'h0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b1, '{1'b0, 2'd0, 2'd0}}
   };

   priority_level_round_robin_arbiter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_request_mask (req_request_mask),
      .req_level_port0  (req_level_port0),
      .req_level_port1  (req_level_port1),
      .req_level_port2  (req_level_port2),
      .req_level_port3  (req_level_port3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_grant_valid  (rsp_grant_valid),
      .rsp_grant_port   (rsp_grant_port),
      .rsp_grant_level  (rsp_grant_level)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // highest level first; round-robin within a level from one past its last grant
   function automatic grant_type arbitrate(mask_type m, level_type a, level_type b,
                                           level_type c, level_type d);
      level_type lv [FIELD_PORTS];
      grant_type g;
      port_type  p;
      int        lev;
      int        k;
      lv[0] = a;
      lv[1] = b;
      lv[2] = c;
      lv[3] = d;
      g = '0;
      for (lev = FIELD_LEVELS - 1; lev >= 0 && !g.gv; lev--) begin
         p = last_grant_port[lev];
         for (k = 0; k < FIELD_PORTS; k++) begin
            p = p + 1'b1;
            if (!g.gv && m[p] && lv[p] == level_type'(lev)) begin
               g.gv = 1'b1;
               g.port = p;
               g.level = level_type'(lev);
               last_grant_port[lev] = p;
            end
         end
      end
      return g;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < 40)
         $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic offer(mask_type m, level_type a, level_type b, level_type c,
                        level_type d, logic typed, grant_type want);
      grant_type g;
      req_valid        <= 1'b1;
      req_request_mask <= m;
      req_level_port0  <= a;
      req_level_port1  <= b;
      req_level_port2  <= c;
      req_level_port3  <= d;
      do @(posedge clock); while (!req_ready);
      g = arbitrate(m, a, b, c, d);
      exp_fifo[exp_wr % EXP_DEPTH] = typed ? want : g;
      exp_wr++;
      while (!no_idle && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic offer_random();
      mask_type  m;
      level_type lv [FIELD_PORTS];
      int        pick;
      int        i;
      pick = $urandom_range(99);
      if (pick < 10)
         m = '0;
      else if (pick < 35)
         m = '1;
      else
         m = mask_type'($urandom_range(15));
      // a shared level keeps the rotation of one pointer in play
      if ($urandom_range(99) < 25) begin
         lv[0] = level_type'($urandom_range(3));
         for (i = 1; i < FIELD_PORTS; i++)
            lv[i] = lv[0];
      end else begin
         for (i = 0; i < FIELD_PORTS; i++)
            lv[i] = level_type'($urandom_range(3));
      end
      offer(m, lv[0], lv[1], lv[2], lv[3], 1'b0, '0);
   endtask

   initial begin : rsp_side
      int n;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++)
               @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 31);
         end
      end
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_wr == exp_rd) begin
            report_mismatch("transfer with nothing expected", rsp_grant_port, 0);
         end else begin
            want = exp_fifo[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_grant_valid !== want.gv)
               report_mismatch("grant_valid", rsp_grant_valid, want.gv);
            if (rsp_grant_port !== want.port)
               report_mismatch("grant_port", rsp_grant_port, want.port);
            if (rsp_grant_level !== want.level)
               report_mismatch("grant_level", rsp_grant_level, want.level);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : req_side
      int i;
      no_idle          = 1'b0;
      hold_rsp         = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_request_mask <= '0;
      req_level_port0  <= '0;
      req_level_port1  <= '0;
      req_level_port2  <= '0;
      req_level_port3  <= '0;
      for (i = 0; i < FIELD_LEVELS; i++)
         last_grant_port[i] = port_type'(FIELD_PORTS - 1);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         offer(dir_tab[i].mask, dir_tab[i].l0, dir_tab[i].l1, dir_tab[i].l2,
               dir_tab[i].l3, dir_tab[i].typed, dir_tab[i].want);

      for (i = 0; i < 300; i++)
         offer_random();

      // sender pause: let every grant drain
      req_valid <= 1'b0;
      while (exp_wr != exp_rd)
         @(posedge clock);
      @(posedge clock);

      // receiver holds off while items keep coming, so the input stalls
      hold_rsp = 1'b1;
      for (i = 0; i < 30; i++)
         offer_random();

      no_idle = 1'b1;
      for (i = 0; i < 250; i++)
         offer_random();
      no_idle = 1'b0;

      for (i = 0; i < 370; i++)
         offer_random();

      req_valid <= 1'b0;
      while (exp_wr != exp_rd)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
